>>> rtl/positional_pi_controller_antiwindup_macros.svh
// Assertion macros of the controller's top-level RTL file.
`ifndef POSITIONAL_PI_CONTROLLER_ANTIWINDUP_MACROS_SVH
`define POSITIONAL_PI_CONTROLLER_ANTIWINDUP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPCA_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PPCA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ppca_pkg.sv
// Shared types, constants and helpers of the positional PI controller.
`default_nettype none

package ppca_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned LIM_W     = 31;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned STEP_W    = 4;

    // Decay factor numerator over 2^16 (about 0.99)
    localparam logic [15:0] DECAY_NUM = 16'd64881;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SP_LIM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIM = 3'd5;

    // Operand pair of the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KI_SUM,
        MUL_KP_ERR,
        MUL_HI_TS,
        MUL_LO_TS,
        MUL_DECAY
    } ppca_mul_t;

    // Datapath register transfer of one step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_IABS,
        OP_PTERM,
        OP_THI,
        OP_TSUM,
        OP_INEG,
        OP_ADD,
        OP_CLAMP,
        OP_INTG,
        OP_DABS,
        OP_DRES,
        OP_OUT
    } ppca_op_t;

    // Sequencer branch kind
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_DECAY
    } ppca_jmp_t;

    typedef struct packed {
        ppca_op_t  op;
        ppca_mul_t mul;
    } ppca_ctrl_t;

    typedef struct packed {
        ppca_op_t            op;
        ppca_mul_t           mul;
        logic                wait_in;
        logic                wait_out;
        ppca_jmp_t           jmp;
        logic [STEP_W-1:0]   target;
    } ppca_uword_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] kp;
        logic signed [DATA_W-1:0] ki;
        logic [DATA_W-1:0]        ts;
        logic [LIM_W-1:0]         sp_lim;
        logic [LIM_W-1:0]         out_lim;
        logic [LIM_W-1:0]         int_lim;
    } ppca_cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] peak_high;
        logic signed [DATA_W-1:0] peak_low;
    } ppca_result_t;

    // Clamp a wide signed value to +/-lim
    function automatic logic signed [DATA_W-1:0] clamp_sym(
        input logic signed [63:0] x,
        input logic [LIM_W-1:0]   lim
    );
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = $signed({33'd0, lim});
        lo = -hi;
        priority if (x > hi)
            return hi[DATA_W-1:0];
        else if (x < lo)
            return lo[DATA_W-1:0];
        else
            return x[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/ppca_if.sv
// Sample and result channel interfaces of the controller.
`default_nettype none

interface ppca_sample_if
    import ppca_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] target;
    logic                     clear_integral;

    modport source (output valid, output measured, output target,
                    output clear_integral, input ready);
    modport sink (input valid, input measured, input target,
                  input clear_integral, output ready);
endinterface

interface ppca_result_if
    import ppca_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] peak_high;
    logic signed [DATA_W-1:0] peak_low;

    modport source (output valid, output drive, output peak_high,
                    output peak_low, input ready);
    modport sink (input valid, input drive, input peak_high,
                  input peak_low, output ready);
endinterface

`default_nettype wire

>>> rtl/ppca_datapath.sv
// Datapath of the PI controller: shared multiplier, work registers and state.
`default_nettype none

module ppca_datapath
    import ppca_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ppca_ctrl_t               ctrl,
    input  wire ppca_cfg_t                cfg,
    input  wire logic signed [DATA_W-1:0] measured,
    input  wire logic signed [DATA_W-1:0] target,
    input  wire logic                     clear_integral,
    output logic                          decay,
    output ppca_result_t                  result
);

    // State registers
    logic signed [DATA_W-1:0] esum_reg, esum_next;
    logic signed [DATA_W-1:0] dmax_reg, dmax_next;
    logic signed [DATA_W-1:0] dmin_reg, dmin_next;

    // Work registers
    logic signed [DATA_W-1:0] meas_reg, meas_next;
    logic signed [DATA_W-1:0] sp_reg, sp_next;
    logic signed [DATA_W:0]   err_reg, err_next;
    logic signed [67:0]       prod_reg;
    logic [61:0]              mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic signed [63:0]       acc_reg, acc_next;
    logic [62:0]              t_reg, t_next;
    logic signed [47:0]       ui_reg, ui_next;
    logic signed [DATA_W-1:0] drive_reg, drive_next;
    logic signed [33:0]       cand_reg, cand_next;

    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [63:0] ip_abs;
    logic signed [DATA_W:0] esum_abs;
    logic signed [DATA_W:0] lim_pos;
    logic                 unsat;
    logic signed [47:0]   ui_mag;
    logic signed [33:0]   dres_mag;

    // Select multiplier operands
    always_comb
    begin
        unique case (ctrl.mul)
            MUL_KI_SUM:
            begin
                mul_a = {{2{cfg.ki[DATA_W-1]}}, cfg.ki};
                mul_b = {{2{esum_reg[DATA_W-1]}}, esum_reg};
            end
            MUL_KP_ERR:
            begin
                mul_a = {{2{cfg.kp[DATA_W-1]}}, cfg.kp};
                mul_b = {err_reg[DATA_W], err_reg};
            end
            MUL_HI_TS:
            begin
                mul_a = {4'd0, mag_reg[61:32]};
                mul_b = {2'd0, cfg.ts};
            end
            MUL_LO_TS:
            begin
                mul_a = {2'd0, mag_reg[31:0]};
                mul_b = {2'd0, cfg.ts};
            end
            MUL_DECAY:
            begin
                mul_a = {2'd0, mag_reg[31:0]};
                mul_b = {18'd0, DECAY_NUM};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Register every product
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Helper terms
    always_comb
    begin
        ip_abs   = prod_reg[63] ? -prod_reg[63:0] : prod_reg[63:0];
        esum_abs = esum_reg[DATA_W-1] ? -{esum_reg[DATA_W-1], esum_reg}
                                      : {esum_reg[DATA_W-1], esum_reg};
        lim_pos  = $signed({2'b00, cfg.out_lim});
        unsat    = ({drive_reg[DATA_W-1], drive_reg} != lim_pos)
                && ({drive_reg[DATA_W-1], drive_reg} != -lim_pos);
        ui_mag   = $signed({1'b0, t_reg[62:16]});
        dres_mag = $signed({2'b00, prod_reg[47:16]});
    end

    // Step transfers
    always_comb
    begin
        esum_next  = esum_reg;
        dmax_next  = dmax_reg;
        dmin_next  = dmin_reg;
        meas_next  = meas_reg;
        sp_next    = sp_reg;
        err_next   = err_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        t_next     = t_reg;
        ui_next    = ui_reg;
        drive_next = drive_reg;
        cand_next  = cand_reg;
        unique case (ctrl.op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                meas_next = measured;
                sp_next   = clamp_sym({{32{target[DATA_W-1]}}, target}, cfg.sp_lim);
                if (cfg.ki == '0 || clear_integral)
                    esum_next = '0;
            end
            OP_ERR:
                err_next = {sp_reg[DATA_W-1], sp_reg} - {meas_reg[DATA_W-1], meas_reg};
            OP_IABS:
            begin
                neg_next = prod_reg[63];
                mag_next = ip_abs[61:0];
            end
            OP_PTERM:
                acc_next = {{15{prod_reg[64]}}, prod_reg[64:16]};
            OP_THI:
                t_next = {1'b0, prod_reg[61:0]};
            OP_TSUM:
                t_next = t_reg + {31'd0, prod_reg[63:32]};
            OP_INEG:
                ui_next = neg_reg ? -ui_mag : ui_mag;
            OP_ADD:
                acc_next = acc_reg + {{16{ui_reg[47]}}, ui_reg};
            OP_CLAMP:
                drive_next = clamp_sym(acc_reg, cfg.out_lim);
            OP_INTG:
                cand_next = {{2{esum_reg[DATA_W-1]}}, esum_reg}
                          + (unsat ? {err_reg[DATA_W], err_reg} : 34'sd0);
            OP_DABS:
            begin
                neg_next = esum_reg[DATA_W-1];
                mag_next = {29'd0, esum_abs};
            end
            OP_DRES:
                cand_next = neg_reg ? -dres_mag : dres_mag;
            OP_OUT:
            begin
                esum_next = clamp_sym({{30{cand_reg[33]}}, cand_reg}, cfg.int_lim);
                dmax_next = result.peak_high;
                dmin_next = result.peak_low;
            end
            default:
            begin
            end
        endcase
    end

    // Hold controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esum_reg <= '0;
            dmax_reg <= '0;
            dmin_reg <= '0;
        end
        else
        begin
            esum_reg <= esum_next;
            dmax_reg <= dmax_next;
            dmin_reg <= dmin_next;
        end
    end

    // Advance work registers
    always_ff @(posedge clk)
    begin
        meas_reg  <= meas_next;
        sp_reg    <= sp_next;
        err_reg   <= err_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        t_reg     <= t_next;
        ui_reg    <= ui_next;
        drive_reg <= drive_next;
        cand_reg  <= cand_next;
    end

    // Branch flag and result word
    assign decay            = (err_reg == '0) || (sp_reg == '0);
    assign result.drive     = drive_reg;
    assign result.peak_high = (drive_reg > dmax_reg) ? drive_reg : dmax_reg;
    assign result.peak_low  = (drive_reg < dmin_reg) ? drive_reg : dmin_reg;

endmodule

`default_nettype wire

>>> rtl/positional_pi_controller_antiwindup.sv
// A 14-step microprogram drives one shared 34x34 multiplier, which sets the step
// count; a decay of the error sum takes a longer path of steps. The last step holds
// while an untaken result word waits and the result channel is not ready, and a new
// sample is taken only once the program is back at its wait step.
// Reset (rst_n low, asynchronous): gains and period clear to 0, limits go to
// full scale, error sum and drive peaks clear to 0, the result channel empties.
`default_nettype none

`include "positional_pi_controller_antiwindup_macros.svh"

module positional_pi_controller_antiwindup
    import ppca_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    ppca_sample_if.sink               sample,
    ppca_result_if.source             result
);

    // Microprogram step addresses
    localparam logic [STEP_W-1:0] S_WAIT  = 4'd0;
    localparam logic [STEP_W-1:0] S_ERR   = 4'd1;
    localparam logic [STEP_W-1:0] S_IABS  = 4'd2;
    localparam logic [STEP_W-1:0] S_PTERM = 4'd3;
    localparam logic [STEP_W-1:0] S_THI   = 4'd4;
    localparam logic [STEP_W-1:0] S_TSUM  = 4'd5;
    localparam logic [STEP_W-1:0] S_INEG  = 4'd6;
    localparam logic [STEP_W-1:0] S_ADD   = 4'd7;
    localparam logic [STEP_W-1:0] S_CLAMP = 4'd8;
    localparam logic [STEP_W-1:0] S_INTG  = 4'd9;
    localparam logic [STEP_W-1:0] S_DABS  = 4'd10;
    localparam logic [STEP_W-1:0] S_DMUL  = 4'd11;
    localparam logic [STEP_W-1:0] S_DRES  = 4'd12;
    localparam logic [STEP_W-1:0] S_OUT   = 4'd13;

    // Control store: one word per step
    function automatic ppca_uword_t ucode(input logic [STEP_W-1:0] step);
        ppca_uword_t w;
        w = '{op: OP_NONE, mul: MUL_NONE, wait_in: 1'b0, wait_out: 1'b0,
              jmp: JMP_ALWAYS, target: S_WAIT};
        unique case (step)
            S_WAIT:  w = '{OP_LOAD,  MUL_NONE,   1'b1, 1'b0, JMP_NEXT,   S_WAIT};
            S_ERR:   w = '{OP_ERR,   MUL_KI_SUM, 1'b0, 1'b0, JMP_NEXT,   S_WAIT};
            S_IABS:  w = '{OP_IABS,  MUL_KP_ERR, 1'b0, 1'b0, JMP_NEXT,   S_WAIT};
            S_PTERM: w = '{OP_PTERM, MUL_HI_TS,  1'b0, 1'b0, JMP_NEXT,   S_WAIT};
            S_THI:   w = '{OP_THI,   MUL_LO_TS,  1'b0, 1'b0, JMP_NEXT,   S_WAIT};
            S_TSUM:  w = '{OP_TSUM,  MUL_NONE,   1'b0, 1'b0, JMP_NEXT,   S_WAIT};
            S_INEG:  w = '{OP_INEG,  MUL_NONE,   1'b0, 1'b0, JMP_NEXT,   S_WAIT};
            S_ADD:   w = '{OP_ADD,   MUL_NONE,   1'b0, 1'b0, JMP_NEXT,   S_WAIT};
            S_CLAMP: w = '{OP_CLAMP, MUL_NONE,   1'b0, 1'b0, JMP_DECAY,  S_DABS};
            S_INTG:  w = '{OP_INTG,  MUL_NONE,   1'b0, 1'b0, JMP_ALWAYS, S_OUT};
            S_DABS:  w = '{OP_DABS,  MUL_NONE,   1'b0, 1'b0, JMP_NEXT,   S_WAIT};
            S_DMUL:  w = '{OP_NONE,  MUL_DECAY,  1'b0, 1'b0, JMP_NEXT,   S_WAIT};
            S_DRES:  w = '{OP_DRES,  MUL_NONE,   1'b0, 1'b0, JMP_NEXT,   S_WAIT};
            S_OUT:   w = '{OP_OUT,   MUL_NONE,   1'b0, 1'b1, JMP_ALWAYS, S_WAIT};
            default: w = '{OP_NONE,  MUL_NONE,   1'b0, 1'b0, JMP_ALWAYS, S_WAIT};
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] step_reg, step_next;
    ppca_cfg_t         cfg_reg, cfg_next;
    logic              out_valid_reg, out_valid_next;
    ppca_result_t      out_word_reg;

    ppca_uword_t  uw;
    ppca_ctrl_t   ctrl;
    ppca_result_t dp_result;
    logic         decay;
    logic         stall;

    // Decode the current control word
    always_comb
    begin
        uw    = ucode(step_reg);
        stall = (uw.wait_in && !sample.valid)
             || (uw.wait_out && out_valid_reg && !result.ready);
        ctrl.op  = stall ? OP_NONE : uw.op;
        ctrl.mul = uw.mul;
    end

    assign sample.ready = uw.wait_in;

    // Sequence: hold on stall, branch or step on
    always_comb
    begin
        step_next = step_reg;
        if (!stall)
        begin
            unique case (uw.jmp)
                JMP_NEXT:   step_next = step_reg + 4'd1;
                JMP_ALWAYS: step_next = uw.target;
                JMP_DECAY:  step_next = decay ? uw.target : step_reg + 4'd1;
                default:    step_next = S_WAIT;
            endcase
        end
    end

    // Configuration writes; unknown indexes drop
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KP:      cfg_next.kp      = $signed(cfg_data);
                REG_KI:      cfg_next.ki      = $signed(cfg_data);
                REG_TS:      cfg_next.ts      = cfg_data;
                REG_SP_LIM:  cfg_next.sp_lim  = cfg_data[LIM_W-1:0];
                REG_OUT_LIM: cfg_next.out_lim = cfg_data[LIM_W-1:0];
                REG_INT_LIM: cfg_next.int_lim = cfg_data[LIM_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    // Result register: load on the last step, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.op == OP_OUT)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= S_WAIT;
            cfg_reg.kp      <= '0;
            cfg_reg.ki      <= '0;
            cfg_reg.ts      <= '0;
            cfg_reg.sp_lim  <= '1;
            cfg_reg.out_lim <= '1;
            cfg_reg.int_lim <= '1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_OUT)
            out_word_reg <= dp_result;
    end

    ppca_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cfg            (cfg_reg),
        .measured       (sample.measured),
        .target         (sample.target),
        .clear_integral (sample.clear_integral),
        .decay          (decay),
        .result         (dp_result)
    );

    // Drive the result channel
    assign result.valid     = out_valid_reg;
    assign result.drive     = out_word_reg.drive;
    assign result.peak_high = out_word_reg.peak_high;
    assign result.peak_low  = out_word_reg.peak_low;

    // Checks
    `PPCA_ASSERT_NEXT(a_accept_starts_program, sample.valid && sample.ready, step_reg == S_ERR, "accepted sample did not start the program")
    `PPCA_ASSERT_IMPLY(a_peak_signs, result.valid, !result.peak_high[DATA_W-1] && (result.peak_low[DATA_W-1] || result.peak_low == '0), "peak word has wrong sign")
    `PPCA_ASSERT_IMPLY(a_drive_within_peaks, result.valid, (result.drive <= result.peak_high) && (result.drive >= result.peak_low), "drive outside its peaks")

endmodule

`default_nettype wire

>>> tb/pi_drive_checker.sv
// Checker for the PI controller: mirrors register writes, predicts each drive word, compares.
`timescale 1ns / 1ps

module pi_drive_checker
    import ppca_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    ppca_sample_if               samples,
    ppca_result_if               results,
    output int                   mismatches,
    output int                   outstanding,
    output int                   compared
);

    // Shadow copy of the registers and the controller state
    ppca_cfg_t                regs;
    logic signed [DATA_W-1:0] err_acc;
    logic signed [DATA_W-1:0] peak_hi;
    logic signed [DATA_W-1:0] peak_lo;
    ppca_result_t             drive_due[$];

    // Symmetric clamp of a wide value to +/-lim
    function automatic longint limit_sym(input longint x, input logic [LIM_W-1:0] lim);
        longint bound;
        bound = longint'({33'd0, lim});
        if (x > bound)
            return bound;
        if (x < -bound)
            return -bound;
        return x;
    endfunction

    // Advance the shadow controller by one sample and return the word it should emit
    function automatic ppca_result_t predict_drive(
        input logic signed [DATA_W-1:0] meas,
        input logic signed [DATA_W-1:0] tgt,
        input logic                     clr
    );
        longint       sp;
        longint       err;
        longint       p_term;
        longint       i_term;
        longint       prod;
        longint       mag;
        longint       drv;
        longint       isum;
        logic [127:0] wide;
        logic [63:0]  i_mag;
        bit           neg;
        ppca_result_t word;

        sp   = limit_sym(longint'(tgt), regs.sp_lim);
        isum = longint'(err_acc);
        if (regs.ki == 0 || clr)
            isum = 0;

        err    = sp - longint'(meas);
        p_term = (longint'($signed(regs.kp)) * err) >>> 16;

        // Integral term: ki * sum * period / 2^48, truncated toward zero
        prod  = longint'($signed(regs.ki)) * isum;
        neg   = prod < 0;
        mag   = neg ? -prod : prod;
        wide  = {64'd0, mag} * {96'd0, regs.ts};
        i_mag = wide[111:48];
        i_term = neg ? -longint'(i_mag) : longint'(i_mag);

        drv = limit_sym(p_term + i_term, regs.out_lim);

        // Decay on zero error or zero setpoint, else integrate unless saturated
        if (err == 0 || sp == 0) begin
            neg  = isum < 0;
            mag  = neg ? -isum : isum;
            mag  = (mag * longint'(DECAY_NUM)) >>> 16;
            isum = neg ? -mag : mag;
        end
        else if ((drv < 0 ? -drv : drv) < longint'({33'd0, regs.out_lim})) begin
            isum = isum + err;
        end
        isum    = limit_sym(isum, regs.int_lim);
        err_acc = isum[DATA_W-1:0];

        if (drv > longint'(peak_hi))
            peak_hi = drv[DATA_W-1:0];
        if (drv < longint'(peak_lo))
            peak_lo = drv[DATA_W-1:0];

        word.drive     = drv[DATA_W-1:0];
        word.peak_high = peak_hi;
        word.peak_low  = peak_lo;
        return word;
    endfunction

    task automatic check_field(
        input string                    label,
        input logic signed [DATA_W-1:0] want,
        input logic signed [DATA_W-1:0] got
    );
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d (0x%08h), got %0d (0x%08h)",
                     $time, label, want, want, got, got);
        end
    endtask

    // Track writes, queue predictions on accepted samples, compare accepted words
    always @(posedge clk or negedge rst_n) begin
        ppca_result_t want;
        if (!rst_n) begin
            regs.kp      = '0;
            regs.ki      = '0;
            regs.ts      = '0;
            regs.sp_lim  = '1;
            regs.out_lim = '1;
            regs.int_lim = '1;
            err_acc      = '0;
            peak_hi      = '0;
            peak_lo      = '0;
            drive_due.delete();
            mismatches   = 0;
            outstanding  = 0;
            compared     = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_KP:      regs.kp = cfg_data;
                    REG_KI:      regs.ki = cfg_data;
                    REG_TS:      regs.ts = cfg_data;
                    REG_SP_LIM:  regs.sp_lim = cfg_data[LIM_W-1:0];
                    REG_OUT_LIM: regs.out_lim = cfg_data[LIM_W-1:0];
                    REG_INT_LIM: regs.int_lim = cfg_data[LIM_W-1:0];
                    default:     ;
                endcase
            end

            if (samples.valid && samples.ready)
                drive_due.push_back(predict_drive(samples.measured, samples.target,
                                                  samples.clear_integral));

            if (results.valid && results.ready) begin
                if (drive_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with nothing pending, drive %0d",
                             $time, results.drive);
                end
                else begin
                    want = drive_due.pop_front();
                    check_field("drive", want.drive, results.drive);
                    check_field("peak_high", want.peak_high, results.peak_high);
                    check_field("peak_low", want.peak_low, results.peak_low);
                    compared++;
                end
            end
            outstanding = drive_due.size();
        end
    end

endmodule

>>> tb/tb_positional_pi_controller_antiwindup.sv
// Top of the PI controller testbench: clock, reset, register setup, sample traffic, verdict.
`timescale 1ns / 1ps

module tb_positional_pi_controller_antiwindup;
    import ppca_pkg::*;

    // Indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int          SETTLE_CYCLES = 16;
    localparam int          RANDOM_PHASES = 9;
    localparam int          PHASE_ITEMS   = 56;
    localparam logic [31:0] Q_ONE         = 32'h0001_0000;
    localparam logic [31:0] Q_TEN         = 32'h000a_0000;
    localparam logic [31:0] Q_HUNDRED     = 32'h0064_0000;
    localparam logic [31:0] POS_FULL      = 32'h7fff_ffff;
    localparam logic [31:0] NEG_FULL      = 32'h8000_0000;

    typedef enum int {
        SET_TYPICAL,
        SET_RANDOM,
        SET_MAX_POS,
        SET_MAX_MIXED,
        SET_ZERO_LIMITS
    } setting_kind_t;

    typedef enum int {
        RX_OPEN,
        RX_SPARSE,
        RX_RANDOM,
        RX_LONG
    } rx_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    int                   mismatches;
    int                   outstanding;
    int                   compared;
    int                   sent;
    int                   settings_used;

    setting_kind_t plan[RANDOM_PHASES] = '{SET_TYPICAL, SET_RANDOM, SET_MAX_POS,
                                           SET_TYPICAL, SET_MAX_MIXED, SET_ZERO_LIMITS,
                                           SET_RANDOM, SET_TYPICAL, SET_TYPICAL};

    ppca_sample_if sample_ch ();
    ppca_result_if result_ch ();

    positional_pi_controller_antiwindup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    pi_drive_checker pi_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .samples     (sample_ch),
        .results     (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result channel backpressure: switch among open, sparse, random and long-hold patterns
    initial
    begin
        rx_mode_t mode;
        int       cyc;
        result_ch.ready = 1'b0;
        mode = RX_OPEN;
        cyc  = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 97 == 0)
                mode = rx_mode_t'($urandom_range(0, 3));
            case (mode)
                RX_OPEN:   result_ch.ready <= 1'b1;
                RX_SPARSE: result_ch.ready <= (cyc % 4 != 0);
                RX_RANDOM: result_ch.ready <= 1'($urandom_range(0, 1));
                default:   result_ch.ready <= ((cyc % 32) >= 20);
            endcase
        end
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("positional_pi_controller_antiwindup: mismatch");
        $finish;
    end

    // Offer one sample word and hold it until taken; valid stays high afterwards
    task automatic put_sample(input logic [31:0] m, input logic [31:0] t, input logic clr);
        sample_ch.valid          <= 1'b1;
        sample_ch.measured       <= m;
        sample_ch.target         <= t;
        sample_ch.clear_integral <= clr;
        do
            @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready));
        @(negedge clk);
        sent++;
    endtask

    // Drop valid for a pause given by n; zero means keep streaming
    task automatic pause(input int n);
        if (n > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Hold off until every pending word has come back, then let the block settle
    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // Load all six registers; the spare bit 31 of each limit word is random
    task automatic apply_settings(input ppca_cfg_t s, input bit with_spare);
        write_reg(REG_KP, s.kp);
        write_reg(REG_KI, s.ki);
        write_reg(REG_TS, s.ts);
        write_reg(REG_SP_LIM, {1'($urandom_range(0, 1)), s.sp_lim});
        write_reg(REG_OUT_LIM, {1'($urandom_range(0, 1)), s.out_lim});
        write_reg(REG_INT_LIM, {1'($urandom_range(0, 1)), s.int_lim});
        if (with_spare)
        begin
            write_reg(REG_SPARE_A, '1);
            write_reg(REG_SPARE_B, 32'h5a5a_a5a5);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic ppca_cfg_t rand_settings(input setting_kind_t kind);
        ppca_cfg_t s;
        case (kind)
            SET_TYPICAL:
            begin
                s.kp      = 32'($signed($urandom) >>> $urandom_range(10, 15));
                s.ki      = 32'($signed($urandom) >>> $urandom_range(6, 14));
                s.ts      = $urandom >> $urandom_range(0, 12);
                s.sp_lim  = 31'($urandom >> $urandom_range(1, 12));
                s.out_lim = 31'($urandom >> $urandom_range(1, 12));
                s.int_lim = 31'($urandom >> $urandom_range(1, 12));
            end
            SET_RANDOM:
            begin
                s.kp      = $urandom;
                s.ki      = $urandom;
                s.ts      = $urandom;
                s.sp_lim  = 31'($urandom);
                s.out_lim = 31'($urandom);
                s.int_lim = 31'($urandom);
            end
            SET_MAX_POS:
            begin
                s.kp      = POS_FULL;
                s.ki      = POS_FULL;
                s.ts      = '1;
                s.sp_lim  = '1;
                s.out_lim = '1;
                s.int_lim = '1;
            end
            SET_MAX_MIXED:
            begin
                s.kp      = NEG_FULL;
                s.ki      = NEG_FULL;
                s.ts      = '1;
                s.sp_lim  = '1;
                s.out_lim = '1;
                s.int_lim = '1;
            end
            default:
            begin
                s.kp      = 32'($signed($urandom) >>> $urandom_range(8, 14));
                s.ki      = 32'd0;
                s.ts      = $urandom;
                s.sp_lim  = $urandom_range(0, 1) ? 31'd0 : 31'($urandom);
                s.out_lim = $urandom_range(0, 1) ? 31'd0 : 31'($urandom >> 4);
                s.int_lim = 31'd0;
            end
        endcase
        return s;
    endfunction

    // Mostly tracking samples near the setpoint, with settled, zero-setpoint and raw noise
    task automatic send_random_item();
        int          pick;
        logic [31:0] t;
        logic [31:0] m;
        logic        clr;
        pick = $urandom_range(0, 99);
        t    = 32'($signed($urandom) >>> $urandom_range(0, 31));
        clr  = ($urandom_range(0, 19) == 0);
        if (pick < 60)
            m = t - 32'($signed($urandom) >>> $urandom_range(4, 31));
        else if (pick < 72)
            m = t;
        else if (pick < 78)
        begin
            m = 32'($signed($urandom) >>> $urandom_range(0, 31));
            t = '0;
        end
        else
        begin
            m = $urandom;
            t = $urandom;
        end
        put_sample(m, t, clr);
    endtask

    // Bursts of samples with random gaps when enabled and the occasional full hold-off
    task automatic run_random(input int count, input bit gaps);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                send_random_item();
                left--;
            end
            if ($urandom_range(0, 9) == 0)
                drain();
            else if (gaps && $urandom_range(0, 2) != 0)
                pause($urandom_range(1, 14));
        end
    endtask

    initial
    begin
        ppca_cfg_t s;
        sample_ch.valid          = 1'b0;
        sample_ch.measured       = '0;
        sample_ch.target         = '0;
        sample_ch.clear_integral = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        sent          = 0;
        settings_used = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: zero gains give zero drive
        put_sample('0, '0, 1'b0);
        put_sample(POS_FULL, NEG_FULL, 1'b0);
        drain();

        // Moderate loop: integrate, clamp setpoint, saturate, decay, clear
        s = '{kp: Q_ONE, ki: 32'h0000_8000, ts: 32'h1000_0000,
              sp_lim: 31'h0064_0000, out_lim: 31'h0032_0000, int_lim: 31'h00c8_0000};
        apply_settings(s, 1'b1);
        put_sample('0, Q_TEN, 1'b0);
        put_sample('0, Q_TEN, 1'b0);
        put_sample('0, Q_TEN, 1'b0);
        put_sample('0, POS_FULL, 1'b0);
        put_sample('0, NEG_FULL, 1'b0);
        put_sample(32'h0005_0000, 32'h0005_0000, 1'b0);
        put_sample(32'h0003_0000, '0, 1'b0);
        put_sample('0, Q_TEN, 1'b1);
        put_sample(POS_FULL, '0, 1'b0);
        put_sample(NEG_FULL, POS_FULL, 1'b0);
        put_sample(32'hfffe_0000, 32'hfff0_0000, 1'b0);
        drain();

        // Zero limits force everything to zero
        s = '{kp: POS_FULL, ki: POS_FULL, ts: '1, sp_lim: '0, out_lim: '0, int_lim: '0};
        apply_settings(s, 1'b0);
        put_sample(NEG_FULL, POS_FULL, 1'b0);
        put_sample(32'd1, 32'd1, 1'b0);
        put_sample(POS_FULL, NEG_FULL, 1'b1);
        drain();

        // Zero ki keeps the sum cleared; negative kp at full error
        s = '{kp: 32'hffff_0000, ki: '0, ts: 32'h8000_0000,
              sp_lim: '1, out_lim: '1, int_lim: '1};
        apply_settings(s, 1'b0);
        put_sample('0, Q_HUNDRED, 1'b0);
        put_sample(Q_HUNDRED, '0, 1'b0);
        put_sample(NEG_FULL, POS_FULL, 1'b0);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            apply_settings(rand_settings(plan[ph]), 1'b0);
            run_random(PHASE_ITEMS, ph != 3);
            drain();
        end

        $display("Covered %0d samples under %0d register settings; %0d result words checked.",
                 sent, settings_used, compared);
        if (mismatches == 0 && outstanding == 0)
            $display("positional_pi_controller_antiwindup: match");
        else
            $display("positional_pi_controller_antiwindup: mismatch");
        $finish;
    end

endmodule
